[rtl/qpg_pkg.sv]
// ----------------------------------------------------------------------------
// qpg_pkg
// Shared widths, register map, reset values and types of the quadrature
// pulse generator.
// ----------------------------------------------------------------------------
package qpg_pkg;

    // default sizing handed to the top level parameters
    localparam int ADC_BITS_DEF   = 10;
    localparam int COUNT_BITS_DEF = 16;

    // payload field widths
    localparam int POT_W  = 10;
    localparam int FREQ_W = 11;

    // configuration register widths
    localparam int DZ_W   = 10;
    localparam int MAXF_W = 10;
    localparam int TPS_W  = 16;

    // apb port
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;
    localparam int INDEX_W = ADDR_W - 2;

    // register indexes
    localparam logic [INDEX_W-1:0] REG_DEAD_ZONE     = 2'd0;
    localparam logic [INDEX_W-1:0] REG_MAX_FREQUENCY = 2'd1;
    localparam logic [INDEX_W-1:0] REG_TICKS_PER_SEC = 2'd2;

    // reset values of the registers
    localparam logic [DZ_W-1:0]   DEAD_ZONE_RST = 10'd1;
    localparam logic [MAXF_W-1:0] MAX_FREQ_RST  = 10'd140;
    localparam logic [TPS_W-1:0]  TPS_RST       = 16'd1000;

    // input queue depth
    localparam int QUEUE_DEPTH = 2;

    // one tick word as held in the input queue
    typedef struct packed {
        logic             run_enable;
        logic [POT_W-1:0] pot_value;
    } item_t;

    // live configuration seen by the sequencer
    typedef struct packed {
        logic [DZ_W-1:0]   dead_zone;
        logic [MAXF_W-1:0] max_frequency;
        logic [TPS_W-1:0]  ticks_per_second;
    } cfg_t;

endpackage

[rtl/qpg_if.sv]
// ----------------------------------------------------------------------------
// qpg_in_if / qpg_out_if
// Valid/ready channels carrying tick words in and phase words out.
// ----------------------------------------------------------------------------
interface qpg_in_if;
    logic                      valid;
    logic                      ready;
    logic [qpg_pkg::POT_W-1:0] pot_value;
    logic                      run_enable;

    modport source (output valid, output pot_value, output run_enable, input ready);
    modport sink   (input valid, input pot_value, input run_enable, output ready);
endinterface

interface qpg_out_if;
    logic                              valid;
    logic                              ready;
    logic                              phase_a;
    logic                              phase_b;
    logic signed [qpg_pkg::FREQ_W-1:0] current_frequency;

    modport source (output valid, output phase_a, output phase_b,
                    output current_frequency, input ready);
    modport sink   (input valid, input phase_a, input phase_b,
                    input current_frequency, output ready);
endinterface

[rtl/qpg_front.sv]
// ----------------------------------------------------------------------------
// qpg_front
// Accepts tick words and holds them in a short queue for the sequencer.
// ----------------------------------------------------------------------------
module qpg_front (
    input  logic            clk,
    input  logic            rst_n,
    qpg_in_if.sink          in_ch,
    output logic            q_valid,
    input  logic            q_ready,
    output qpg_pkg::item_t  q_item
);

    localparam int DEPTH = qpg_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    qpg_pkg::item_t   mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    logic             pop;

    // handshake on both sides
    assign in_ch.ready = (count_reg != CNT_W'(DEPTH));
    assign q_valid     = (count_reg != '0);
    assign push        = in_ch.valid && in_ch.ready;
    assign pop         = q_valid && q_ready;
    assign q_item      = mem_reg[rd_ptr_reg];

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg].run_enable <= in_ch.run_enable;
            mem_reg[wr_ptr_reg].pot_value  <= in_ch.pot_value;
        end
    end

endmodule

[rtl/qpg_div.sv]
// ----------------------------------------------------------------------------
// qpg_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module qpg_div #(
    parameter int DW = 21,
    parameter int VW = 10
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);

    localparam int CW = (DW > 1) ? $clog2(DW) : 1;

    logic [DW-1:0] quo_reg;
    logic [VW-1:0] rem_reg;
    logic [VW-1:0] div_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [VW:0]   trial;
    logic          fits;
    logic [VW:0]   diff;

    // one restoring step
    assign trial = {rem_reg, quo_reg[DW-1]};
    assign fits  = (trial >= {1'b0, div_reg});
    assign diff  = trial - {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(DW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DW-2:0], fits};
            rem_reg <= fits ? diff[VW-1:0] : trial[VW-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[rtl/qpg_back.sv]
// ----------------------------------------------------------------------------
// qpg_back
// Sequencer: steps the toggle sequence per tick, samples the pot when idle
// with run enabled and drives the output word register.
// ----------------------------------------------------------------------------
module qpg_back #(
    parameter int ADC_BITS   = qpg_pkg::ADC_BITS_DEF,
    parameter int COUNT_BITS = qpg_pkg::COUNT_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  qpg_pkg::cfg_t  cfg,
    input  logic           q_valid,
    output logic           q_ready,
    input  qpg_pkg::item_t q_item,
    qpg_out_if.source      out_ch
);

    localparam int FW = qpg_pkg::FREQ_W;
    localparam int MW = qpg_pkg::MAXF_W;
    localparam int PW = ADC_BITS + MW + 1;
    localparam int DW = qpg_pkg::TPS_W;
    localparam int VW = MW;
    localparam int WW = (DW > COUNT_BITS) ? DW : COUNT_BITS;
    localparam logic [PW-1:0] FULL = PW'((64'd1 << ADC_BITS) - 64'd1);
    localparam logic [WW-1:0] QMAX = WW'({COUNT_BITS{1'b1}});

    typedef enum logic [2:0] {
        ST_POP, ST_MUL, ST_FOLD, ST_FREQ, ST_DIV_START, ST_DIV_WAIT, ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        STEP_IDLE, STEP_FIRST, STEP_SECOND
    } step_t;

    state_t                state_reg, state_next;
    step_t                 step_reg, step_next;
    logic                  level_a_reg, level_a_next;
    logic                  level_b_reg, level_b_next;
    logic                  rev_reg, rev_next;
    logic [FW-1:0]         freq_reg, freq_next;
    logic [COUNT_BITS-1:0] quarter_reg, quarter_next;
    logic [COUNT_BITS-1:0] tc_reg, tc_next;
    logic [ADC_BITS-1:0]   pot_reg, pot_next;
    logic [PW-1:0]         prod_reg, prod_next;
    logic [PW-1:0]         scaled_reg, scaled_next;
    logic [MW-1:0]         mag_reg, mag_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_a_reg, out_a_next;
    logic                  out_b_reg, out_b_next;
    logic [FW-1:0]         out_freq_reg, out_freq_next;

    logic                  div_start;
    logic [DW-1:0]         div_dividend;
    logic [VW-1:0]         div_divisor;
    logic                  div_done;
    logic [DW-1:0]         div_quotient;

    logic                  out_free;
    logic [COUNT_BITS-1:0] tc_dec;
    logic [FW-1:0]         freq_abs;
    logic [WW-1:0]         q4;
    logic [COUNT_BITS-1:0] quarter_val;
    logic [PW-1:0]         fold_hi;
    logic [PW-1:0]         scaled_fin;

    qpg_div #(
        .DW (DW),
        .VW (VW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // helpers
    assign out_free = !out_valid_reg || out_ch.ready;
    assign tc_dec   = (tc_reg != '0) ? tc_reg - 1'b1 : tc_reg;
    assign freq_abs = freq_reg[FW-1] ? (~freq_reg + 1'b1) : freq_reg;
    assign q4       = WW'(div_quotient >> 2);

    // division by 2^ADC_BITS-1 by folding the high part onto the low part
    assign fold_hi    = prod_reg >> ADC_BITS;
    assign scaled_fin = (prod_reg == FULL) ? scaled_reg + 1'b1 : scaled_reg;

    // quarter length, at least one and saturated to the counter
    always_comb
    begin
        if (q4 == '0)
        begin
            quarter_val = COUNT_BITS'(1);
        end
        else if (q4 > QMAX)
        begin
            quarter_val = QMAX[COUNT_BITS-1:0];
        end
        else
        begin
            quarter_val = q4[COUNT_BITS-1:0];
        end
    end

    // divider operands
    assign div_start    = (state_reg == ST_DIV_START);
    assign div_dividend = cfg.ticks_per_second;
    assign div_divisor  = mag_reg;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        level_a_next   = level_a_reg;
        level_b_next   = level_b_reg;
        rev_next       = rev_reg;
        freq_next      = freq_reg;
        quarter_next   = quarter_reg;
        tc_next        = tc_reg;
        pot_next       = pot_reg;
        prod_next      = prod_reg;
        scaled_next    = scaled_reg;
        mag_next       = mag_reg;
        out_valid_next = out_valid_reg;
        out_a_next     = out_a_reg;
        out_b_next     = out_b_reg;
        out_freq_next  = out_freq_reg;
        q_ready        = 1'b0;

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_POP:
            begin
                q_ready = 1'b1;
                if (q_valid)
                begin
                    state_next = ST_EMIT;
                    if (step_reg != STEP_IDLE)
                    begin
                        // running sequence: count down and toggle
                        tc_next = tc_dec;
                        if (tc_dec == '0)
                        begin
                            if (step_reg == STEP_FIRST)
                            begin
                                if (rev_reg)
                                begin
                                    level_b_next = !level_b_reg;
                                end
                                else
                                begin
                                    level_a_next = !level_a_reg;
                                end
                                tc_next   = quarter_reg;
                                step_next = STEP_SECOND;
                            end
                            else
                            begin
                                if (rev_reg)
                                begin
                                    level_a_next = !level_a_reg;
                                end
                                else
                                begin
                                    level_b_next = !level_b_reg;
                                end
                                step_next = STEP_IDLE;
                            end
                        end
                    end
                    else if (q_item.run_enable)
                    begin
                        pot_next   = ADC_BITS'(q_item.pot_value);
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                prod_next   = PW'(pot_reg) * PW'({cfg.max_frequency, 1'b0});
                scaled_next = '0;
                state_next  = ST_FOLD;
            end
            ST_FOLD:
            begin
                if (fold_hi != '0)
                begin
                    scaled_next = scaled_reg + fold_hi;
                    prod_next   = (prod_reg & FULL) + fold_hi;
                end
                else
                begin
                    freq_next  = scaled_fin[FW-1:0] - {1'b0, cfg.max_frequency};
                    state_next = ST_FREQ;
                end
            end
            ST_FREQ:
            begin
                mag_next = freq_abs[MW-1:0];
                if (freq_abs[MW-1:0] > cfg.dead_zone)
                begin
                    state_next = ST_DIV_START;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_DIV_START:
            begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    quarter_next = quarter_val;
                    tc_next      = quarter_val;
                    rev_next     = freq_reg[FW-1];
                    step_next    = STEP_FIRST;
                    state_next   = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_a_next     = level_a_reg;
                    out_b_next     = level_b_reg;
                    out_freq_next  = freq_reg;
                    state_next     = ST_POP;
                end
            end
            default:
            begin
                state_next = ST_POP;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_POP;
            step_reg      <= STEP_IDLE;
            level_a_reg   <= 1'b0;
            level_b_reg   <= 1'b0;
            rev_reg       <= 1'b0;
            freq_reg      <= '0;
            quarter_reg   <= '0;
            tc_reg        <= '0;
            pot_reg       <= '0;
            prod_reg      <= '0;
            scaled_reg    <= '0;
            mag_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_a_reg     <= 1'b0;
            out_b_reg     <= 1'b0;
            out_freq_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            level_a_reg   <= level_a_next;
            level_b_reg   <= level_b_next;
            rev_reg       <= rev_next;
            freq_reg      <= freq_next;
            quarter_reg   <= quarter_next;
            tc_reg        <= tc_next;
            pot_reg       <= pot_next;
            prod_reg      <= prod_next;
            scaled_reg    <= scaled_next;
            mag_reg       <= mag_next;
            out_valid_reg <= out_valid_next;
            out_a_reg     <= out_a_next;
            out_b_reg     <= out_b_next;
            out_freq_reg  <= out_freq_next;
        end
    end

    // output word
    assign out_ch.valid             = out_valid_reg;
    assign out_ch.phase_a           = out_a_reg;
    assign out_ch.phase_b           = out_b_reg;
    assign out_ch.current_frequency = out_freq_reg;

endmodule

[rtl/quadrature_pulse_generator.sv]
// ----------------------------------------------------------------------------
// quadrature_pulse_generator
// Emulates the two quadrature outputs of a spinning encoder, one tick a word.
//
// in_ch takes one tick word (pot_value, run_enable); out_ch returns one word
// per tick with phase_a, phase_b and the last sampled current_frequency.
// The apb port holds dead_zone, max_frequency and ticks_per_second at byte
// addresses 0, 4 and 8; write them only while no tick is in flight.
// A tick during a running sequence or with run low passes from acceptance
// to out_ch valid through a queue pop with state update and an output load.
// A sampling tick adds a multiply and 1 to 4 fold steps that scale the pot;
// above the dead zone a one-bit-per-cycle divider then gives the quarter
// length. Ticks are handled one at a time.
// If out_ch stalls, the output register holds its word, the sequencer waits
// with the next word, the two-word queue fills and in_ch.ready drops.
// Reset clears the phases, frequency and sequence, and loads the register
// defaults 1, 140 and 1000.
// ----------------------------------------------------------------------------
module quadrature_pulse_generator #(
    parameter int ADC_BITS   = qpg_pkg::ADC_BITS_DEF,
    parameter int COUNT_BITS = qpg_pkg::COUNT_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    qpg_in_if.sink                      in_ch,
    qpg_out_if.source                   out_ch,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [qpg_pkg::ADDR_W-1:0]  paddr,
    input  logic [qpg_pkg::DATA_W-1:0]  pwdata,
    output logic [qpg_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    logic [qpg_pkg::DZ_W-1:0]    dead_zone_reg;
    logic [qpg_pkg::MAXF_W-1:0]  max_freq_reg;
    logic [qpg_pkg::TPS_W-1:0]   tps_reg;
    logic [qpg_pkg::INDEX_W-1:0] reg_index;
    logic                        wr_en;
    qpg_pkg::cfg_t               cfg;
    logic                        q_valid;
    logic                        q_ready;
    qpg_pkg::item_t              q_item;

    // register file
    assign pready    = 1'b1;
    assign reg_index = paddr[qpg_pkg::ADDR_W-1:2];
    assign wr_en     = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dead_zone_reg <= qpg_pkg::DEAD_ZONE_RST;
            max_freq_reg  <= qpg_pkg::MAX_FREQ_RST;
            tps_reg       <= qpg_pkg::TPS_RST;
        end
        else if (wr_en)
        begin
            case (reg_index)
                qpg_pkg::REG_DEAD_ZONE:
                begin
                    dead_zone_reg <= pwdata[qpg_pkg::DZ_W-1:0];
                end
                qpg_pkg::REG_MAX_FREQUENCY:
                begin
                    max_freq_reg <= pwdata[qpg_pkg::MAXF_W-1:0];
                end
                qpg_pkg::REG_TICKS_PER_SEC:
                begin
                    tps_reg <= pwdata[qpg_pkg::TPS_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // read back
    always_comb
    begin
        case (reg_index)
            qpg_pkg::REG_DEAD_ZONE:     prdata = qpg_pkg::DATA_W'(dead_zone_reg);
            qpg_pkg::REG_MAX_FREQUENCY: prdata = qpg_pkg::DATA_W'(max_freq_reg);
            qpg_pkg::REG_TICKS_PER_SEC: prdata = qpg_pkg::DATA_W'(tps_reg);
            default:                    prdata = '0;
        endcase
    end

    assign cfg.dead_zone        = dead_zone_reg;
    assign cfg.max_frequency    = max_freq_reg;
    assign cfg.ticks_per_second = tps_reg;

    // tick queue
    qpg_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item)
    );

    // sequencer and output register
    qpg_back #(
        .ADC_BITS   (ADC_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item),
        .out_ch  (out_ch)
    );

endmodule
